[rtl/ppm_pkg.sv]
// Package: shared types and constants of the periodic position matcher.
package ppm_pkg;

    localparam int MAX_ATOMS_DEF = 64;
    localparam int FRAC_BITS_DEF = 32;

    localparam logic [1:0] CMD_LOAD_LAT = 2'd0;
    localparam logic [1:0] CMD_LOAD_REF = 2'd1;
    localparam logic [1:0] CMD_LOAD_ROT = 2'd2;
    localparam logic [1:0] CMD_RUN      = 2'd3;

    localparam logic CFG_ATOM_COUNT = 1'b0;
    localparam logic CFG_TOLERANCE  = 1'b1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [5:0]         slot;
        logic signed [31:0] lattice_value;
        logic [31:0]        frac_x;
        logic [31:0]        frac_y;
        logic [31:0]        frac_z;
    } in_item_t;

    typedef struct packed {
        logic [5:0] rotated_index;
        logic [5:0] mapped_index;
        logic       matched;
        logic       all_matched;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } pos_t;

    // Control from the sequencer to the row of cells.
    typedef struct packed {
        logic       clear;
        logic       assign_en;
        logic [5:0] ref_index;
        logic       shift;
    } cell_ctrl_t;

endpackage

[rtl/ppm_ram.sv]
// Generic single-port write, single read RAM with registered read data.
module ppm_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

[rtl/ppm_dist.sv]
// Pipelined squared periodic distance between two fractional positions.
module ppm_dist #(
    parameter int FRAC_BITS = ppm_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic [31:0]        lat [9],
    input  ppm_pkg::pos_t      ref_pos,
    input  ppm_pkg::pos_t      rot_pos,
    output logic [63:0]        dist_sq
);
    localparam int CART_SHIFT = 48 - FRAC_BITS;
    localparam int SQ_SHIFT   = 2 * FRAC_BITS - 32;
    localparam int MAG_W      = 66 - CART_SHIFT;
    localparam int HW         = (MAG_W + 1) / 2;

    logic signed [31:0] d_reg [3];
    logic signed [63:0] p_reg [9];
    logic [65:0]        mag_reg [3];
    logic [2*HW-1:0]    phh_reg [3];
    logic [2*HW-1:0]    phl_reg [3];
    logic [2*HW-1:0]    pll_reg [3];
    logic [63:0]        sqs_reg [3];

    // Stage 1: wrapped differences (mod 2^32 read as signed).
    always_ff @(posedge aclk) begin
        d_reg[0] <= $signed(ref_pos.x - rot_pos.x);
        d_reg[1] <= $signed(ref_pos.y - rot_pos.y);
        d_reg[2] <= $signed(ref_pos.z - rot_pos.z);
    end

    // Stage 2: nine products.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 9; i++) begin
            p_reg[i] <= $signed(lat[i]) * d_reg[i % 3];
        end
    end

    // Stage 3: component sums, magnitude truncated toward zero.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            logic signed [65:0] s;
            logic [65:0] m;
            s = 66'(p_reg[3*k]) + 66'(p_reg[3*k+1]) + 66'(p_reg[3*k+2]);
            m = s[65] ? 66'(-s) : 66'(s);
            mag_reg[k] <= m >> CART_SHIFT;
        end
    end

    // Stage 4: split each magnitude in halves and form the partial products.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            logic [HW-1:0] hi;
            logic [HW-1:0] lo;
            hi = HW'(mag_reg[k] >> HW);
            lo = mag_reg[k][HW-1:0];
            phh_reg[k] <= (2*HW)'(hi) * (2*HW)'(hi);
            phl_reg[k] <= (2*HW)'(hi) * (2*HW)'(lo);
            pll_reg[k] <= (2*HW)'(lo) * (2*HW)'(lo);
        end
    end

    // Stage 5: combine the square, scale to Q32.32 and saturate.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            logic [127:0] sq;
            logic [127:0] sh;
            sq = (128'(phh_reg[k]) << (2 * HW)) + (128'(phl_reg[k]) << (HW + 1))
               + 128'(pll_reg[k]);
            sh = sq >> SQ_SHIFT;
            sqs_reg[k] <= (sh[127:64] != '0) ? '1 : sh[63:0];
        end
    end

    // Stage 6: saturating total.
    always_ff @(posedge aclk) begin
        logic [65:0] t;
        t = 66'(sqs_reg[0]) + 66'(sqs_reg[1]) + 66'(sqs_reg[2]);
        dist_sq <= (t[65:64] != 2'b0) ? '1 : t[63:0];
    end
endmodule

[rtl/ppm_cell.sv]
// One cell of the assignment chain: holds the assignment of one rotated position.
module ppm_cell (
    input  logic                aclk,
    input  ppm_pkg::cell_ctrl_t ctrl,
    input  logic                sel,
    input  logic [6:0]          shift_in,
    output logic [6:0]          entry
);
    logic [6:0] entry_reg;

    // Shift hands the entry to the neighbor; clear empties the cell.
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            entry_reg <= '0;
        end else if (ctrl.shift) begin
            entry_reg <= shift_in;
        end else if (ctrl.assign_en && sel) begin
            entry_reg <= {1'b1, ctrl.ref_index};
        end
    end

    assign entry = entry_reg;
endmodule

[rtl/periodic_position_matcher.sv]
// Top level: command decode, position stores, distance pipeline and assignment cell chain.
// A run of n positions scans each reference against the unassigned rotated positions,
// one candidate at a time through the RAM read and the 6-stage distance pipeline.
// Results drain from the cell chain one per cycle, unless m_ready holds them back,
// through a one-entry output register.
// aresetn (synchronous, active low) clears control, atom_count to 1 and tolerance to 0.
module periodic_position_matcher #(
    parameter int MAX_ATOMS = ppm_pkg::MAX_ATOMS_DEF,
    parameter int FRAC_BITS = ppm_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ppm_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ppm_pkg::out_item_t m_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data
);
    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CW = $clog2(MAX_ATOMS + 1);
    localparam int PIPE = 7;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_NEXT, ST_EMIT
    } state_t;

    state_t state_reg;
    logic [6:0]  atom_count_reg;
    logic [63:0] tol_reg;
    logic [31:0] lat_reg [9];
    logic [CW-1:0] n_reg, ri_reg, qi_reg, oi_reg;
    logic [2:0] wait_reg;
    logic all_reg;
    logic out_valid_reg;
    ppm_pkg::out_item_t out_reg;

    ppm_pkg::pos_t ref_q, rot_q;
    logic [63:0] dist_sq;
    logic [6:0] entry [MAX_ATOMS];
    ppm_pkg::cell_ctrl_t ctrl;
    logic [MAX_ATOMS-1:0] sel;

    logic s_acc;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc = s_valid && s_ready;

    logic ld_ref, ld_rot;
    assign ld_ref = s_acc && s_data.cmd == ppm_pkg::CMD_LOAD_REF && 32'(s_data.slot) < MAX_ATOMS;
    assign ld_rot = s_acc && s_data.cmd == ppm_pkg::CMD_LOAD_ROT && 32'(s_data.slot) < MAX_ATOMS;

    ppm_pkg::pos_t wpos;
    assign wpos = '{x: s_data.frac_x, y: s_data.frac_y, z: s_data.frac_z};

    ppm_ram #(.WIDTH(96), .DEPTH(MAX_ATOMS)) u_ref (
        .aclk(aclk), .wr_en(ld_ref), .wr_addr(s_data.slot[AW-1:0]), .wr_data(wpos),
        .rd_addr(ri_reg[AW-1:0]), .rd_data(ref_q)
    );
    ppm_ram #(.WIDTH(96), .DEPTH(MAX_ATOMS)) u_rot (
        .aclk(aclk), .wr_en(ld_rot), .wr_addr(s_data.slot[AW-1:0]), .wr_data(wpos),
        .rd_addr(qi_reg[AW-1:0]), .rd_data(rot_q)
    );

    ppm_dist #(.FRAC_BITS(FRAC_BITS)) u_dist (
        .aclk(aclk), .lat(lat_reg), .ref_pos(ref_q), .rot_pos(rot_q), .dist_sq(dist_sq)
    );

    // Chain of cells; during emit the entries rotate toward cell zero.
    for (genvar g = 0; g < MAX_ATOMS; g++) begin : g_cell
        assign sel[g] = (32'(qi_reg) == g);
        ppm_cell u_cell (
            .aclk(aclk), .ctrl(ctrl), .sel(sel[g]),
            .shift_in(entry[(g + 1) % MAX_ATOMS]), .entry(entry[g])
        );
    end

    // Current candidate's entry and next unassigned candidate after qi.
    logic cur_valid;
    logic [CW-1:0] next_q;
    logic hit;
    assign cur_valid = entry[qi_reg[AW-1:0]][6];
    assign hit = (dist_sq < tol_reg);

    always_comb begin
        next_q = n_reg;
        for (int j = MAX_ATOMS - 1; j >= 0; j--) begin
            if (CW'(j) > qi_reg && CW'(j) < n_reg && !entry[j][6]) begin
                next_q = CW'(j);
            end
        end
    end

    logic [CW-1:0] first_q;
    always_comb begin
        first_q = n_reg;
        for (int j = MAX_ATOMS - 1; j >= 0; j--) begin
            if (CW'(j) < n_reg && !entry[j][6]) begin
                first_q = CW'(j);
            end
        end
    end

    always_comb begin
        ctrl = '0;
        ctrl.ref_index = 6'(ri_reg);
        ctrl.clear = s_acc && s_data.cmd == ppm_pkg::CMD_RUN;
        ctrl.assign_en = (state_reg == ST_WAIT) && wait_reg == '0 && hit;
        ctrl.shift = (state_reg == ST_EMIT) && (!out_valid_reg || m_ready);
    end

    logic all_now;
    always_comb begin
        all_now = 1'b1;
        for (int j = 0; j < MAX_ATOMS; j++) begin
            if (CW'(j) < n_reg && !entry[j][6]) all_now = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            atom_count_reg <= 7'd1;
            tol_reg <= '0;
            out_valid_reg <= 1'b0;
            n_reg <= '0;
            ri_reg <= '0;
            qi_reg <= '0;
            oi_reg <= '0;
            wait_reg <= '0;
            all_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    ppm_pkg::CFG_ATOM_COUNT: atom_count_reg <= cfg_data[6:0];
                    ppm_pkg::CFG_TOLERANCE:  tol_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && s_data.cmd == ppm_pkg::CMD_LOAD_LAT && s_data.slot < 6'd9) begin
                        lat_reg[s_data.slot[3:0]] <= s_data.lattice_value;
                    end
                    if (s_acc && s_data.cmd == ppm_pkg::CMD_RUN) begin
                        n_reg <= (32'(atom_count_reg) > MAX_ATOMS) ? CW'(MAX_ATOMS)
                                                                  : CW'(atom_count_reg);
                        ri_reg <= '0;
                        qi_reg <= '0;
                        state_reg <= (atom_count_reg == '0) ? ST_IDLE : ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (qi_reg >= n_reg) begin
                        state_reg <= ST_NEXT;
                    end else if (cur_valid) begin
                        qi_reg <= next_q;
                    end else begin
                        wait_reg <= 3'(PIPE - 1);
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (wait_reg != '0) begin
                        wait_reg <= wait_reg - 3'd1;
                    end else if (hit) begin
                        state_reg <= ST_NEXT;
                    end else begin
                        qi_reg <= next_q;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_NEXT: begin
                    if (ri_reg + 1'b1 >= n_reg) begin
                        all_reg <= all_now;
                        oi_reg <= '0;
                        state_reg <= ST_EMIT;
                    end else begin
                        ri_reg <= ri_reg + 1'b1;
                        qi_reg <= first_q;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_EMIT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_reg.rotated_index <= 6'(oi_reg);
                        out_reg.mapped_index <= entry[0][6] ? entry[0][5:0] : 6'd0;
                        out_reg.matched <= entry[0][6];
                        out_reg.all_matched <= all_reg;
                        out_reg.last <= (oi_reg + 1'b1 == n_reg);
                        oi_reg <= oi_reg + 1'b1;
                        if (oi_reg + 1'b1 == n_reg) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("item taken while busy");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_assign_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.assign_en |-> (qi_reg < n_reg)) else $error("assign beyond count");
`endif
endmodule
